@@ src/afrc_pkg.sv @@
// Package for the audio frame rate converter.
// Holds register codes, mode codes, blend operation codes and the configuration struct.
// No dependencies.
package afrc_pkg;

	// Number of sample fields in one frame at the ports.
	localparam int CH_FIELDS = 8;

	// Configuration port widths.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 5;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE          = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECIMATION    = 2'd2;

	// Mode codes.
	localparam logic [1:0] MODE_UP2  = 2'd0;
	localparam logic [1:0] MODE_UP4  = 2'd1;
	localparam logic [1:0] MODE_DOWN = 2'd2;

	// Register reset values.
	localparam logic [1:0] MODE_RESET = MODE_UP2;
	localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd2;
	localparam logic [4:0] DECIMATION_RESET = 5'd2;
	localparam logic [4:0] DECIMATION_MAX = 5'd16;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] channel_count;
		logic [4:0] decimation_factor;
	} cfg_t;

	// HELD is the held frame, CUR the current one, Q1/Q3 the 3:1 and 1:3 blends.
	typedef enum logic [2:0] {
		OP_HELD,
		OP_Q1,
		OP_MID,
		OP_Q3,
		OP_CUR
	} blend_op_t;

endpackage

@@ src/afrc_if.sv @@
// Channel interfaces of the audio frame rate converter: frame input, result output and
// configuration write. Depends on afrc_pkg for the configuration port widths.
interface afrc_frame_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample_ch0;
	logic signed [W-1:0] sample_ch1;
	logic signed [W-1:0] sample_ch2;
	logic signed [W-1:0] sample_ch3;
	logic signed [W-1:0] sample_ch4;
	logic signed [W-1:0] sample_ch5;
	logic signed [W-1:0] sample_ch6;
	logic signed [W-1:0] sample_ch7;
	logic end_of_block;

	modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		sample_ch4, sample_ch5, sample_ch6, sample_ch7, end_of_block, input ready);
	modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		sample_ch4, sample_ch5, sample_ch6, sample_ch7, end_of_block, output ready);
endinterface

interface afrc_result_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] out_ch0;
	logic signed [W-1:0] out_ch1;
	logic signed [W-1:0] out_ch2;
	logic signed [W-1:0] out_ch3;
	logic signed [W-1:0] out_ch4;
	logic signed [W-1:0] out_ch5;
	logic signed [W-1:0] out_ch6;
	logic signed [W-1:0] out_ch7;
	logic last_of_run;

	modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		out_ch6, out_ch7, last_of_run, input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		out_ch6, out_ch7, last_of_run, output ready);
endinterface

interface afrc_cfg_if
	import afrc_pkg::*;
	;
	logic valid;
	logic ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/afrc_cfg.sv @@
// Configuration register file of the audio frame rate converter.
// Depends on afrc_pkg for register indexes, reset values and cfg_t.
module afrc_cfg
	import afrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_RESET;
			cfg_q.channel_count <= CHANNEL_COUNT_RESET;
			cfg_q.decimation_factor <= DECIMATION_RESET;
		end else if (wr_valid) begin
			unique case (wr_index)
				REG_MODE: cfg_q.mode <= wr_data[1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= wr_data[3:0];
				REG_DECIMATION: cfg_q.decimation_factor <= wr_data[4:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/afrc_blend.sv @@
// One channel of the blend datapath: held frame, current frame, midpoint or quarter blends.
// Depends on afrc_pkg for blend_op_t.
module afrc_blend
	import afrc_pkg::*;
#(
	parameter int W = 24
) (
	input  logic signed [W-1:0] held,
	input  logic signed [W-1:0] cur,
	input  blend_op_t op,
	output logic signed [W-1:0] y
);

	logic signed [W+1:0] held_w;
	logic signed [W+1:0] cur_w;
	logic signed [W+1:0] sum_mid;
	logic signed [W+1:0] sum_q1;
	logic signed [W+1:0] sum_q3;

	// Two guard bits hold 3a + b; taking the upper bits is a floor shift.
	assign held_w = {{2{held[W-1]}}, held};
	assign cur_w = {{2{cur[W-1]}}, cur};
	assign sum_mid = held_w + cur_w;
	assign sum_q1 = (held_w <<< 1) + held_w + cur_w;
	assign sum_q3 = (cur_w <<< 1) + cur_w + held_w;

	always_comb begin
		case (op)
			OP_HELD: y = held;
			OP_Q1: y = sum_q1[W+1:2];
			OP_MID: y = sum_mid[W:1];
			OP_Q3: y = sum_q3[W+1:2];
			default: y = cur;
		endcase
	end

endmodule

@@ src/afrc_core.sv @@
// Frame sequencer of the audio frame rate converter: held frame state, input stage and
// result register. Depends on afrc_pkg and afrc_blend.
module afrc_core
	import afrc_pkg::*;
#(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_smp [CH_FIELDS],
	input  logic in_eob,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_smp [CH_FIELDS],
	output logic out_last
);

	localparam logic [3:0] MAX_CH = 4'(MAX_CHANNELS);

	// Persistent state.
	logic signed [SAMPLE_BITS-1:0] held_q [MAX_CHANNELS];
	logic held_valid_q;
	logic [3:0] phase_q;

	// Input stage: one accepted item and the results still to send for it.
	logic busy_q;
	logic signed [SAMPLE_BITS-1:0] cur_s1 [MAX_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] held_s1 [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] mask_s1;
	logic [3:0] count_s1;
	logic pair_s1;
	logic x4_s1;
	logic down_s1;
	logic [2:0] idx_q;

	// Result register.
	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_s2 [CH_FIELDS];
	logic out_last_s2;

	logic accept;
	logic load_out;
	logic step_last;
	logic [3:0] act;
	logic [MAX_CHANNELS-1:0] act_mask;
	logic signed [SAMPLE_BITS-1:0] x [MAX_CHANNELS];
	logic is_up;
	logic is_x4;
	logic [3:0] reps;
	logic [3:0] count;
	logic [4:0] dec_m;
	logic [3:0] phase_cur;
	logic [4:0] phase_inc;
	logic ds_emit;
	blend_op_t op;
	logic signed [SAMPLE_BITS-1:0] blend_y [MAX_CHANNELS];
	logic signed [SAMPLE_BITS-1:0] out_next [CH_FIELDS];

	// Active channel count, clamped to 1..MAX_CHANNELS.
	always_comb begin
		if (cfg.channel_count == 4'd0) begin
			act = 4'd1;
		end else if (cfg.channel_count > MAX_CH) begin
			act = MAX_CH;
		end else begin
			act = cfg.channel_count;
		end
	end

	for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_in
		assign act_mask[j] = 4'(j) < act;
		assign x[j] = act_mask[j] ? in_smp[j] : '0;
	end

	// Plan for the offered item.
	assign is_up = (cfg.mode == MODE_UP2) || (cfg.mode == MODE_UP4);
	assign is_x4 = cfg.mode == MODE_UP4;
	assign reps = is_x4 ? 4'd4 : 4'd2;

	always_comb begin
		if (cfg.decimation_factor == 5'd0) begin
			dec_m = 5'd1;
		end else if (cfg.decimation_factor > DECIMATION_MAX) begin
			dec_m = DECIMATION_MAX;
		end else begin
			dec_m = cfg.decimation_factor;
		end
	end

	assign phase_cur = ({1'b0, phase_q} >= dec_m) ? 4'd0 : phase_q;
	assign phase_inc = {1'b0, phase_cur} + 5'd1;
	assign ds_emit = phase_cur == 4'd0;

	always_comb begin
		if (is_up) begin
			count = (held_valid_q ? reps : 4'd0) + (in_eob ? reps : 4'd0);
		end else if (cfg.mode == MODE_DOWN) begin
			count = ds_emit ? 4'd1 : 4'd0;
		end else begin
			count = 4'd0;
		end
	end

	// Handshakes. The stage frees up in the cycle its last result enters the result register.
	assign load_out = busy_q && (!out_valid_q || out_ready);
	assign step_last = ({1'b0, idx_q} + 4'd1) == count_s1;
	assign in_ready = !busy_q || (load_out && step_last);
	assign accept = in_valid && in_ready;

	// Blend selection for the current step.
	always_comb begin
		if (down_s1) begin
			op = pair_s1 ? OP_MID : OP_CUR;
		end else if (pair_s1 && ({1'b0, idx_q} < (x4_s1 ? 4'd4 : 4'd2))) begin
			if (idx_q == 3'd0) begin
				op = OP_HELD;
			end else if (!x4_s1) begin
				op = OP_MID;
			end else begin
				case (idx_q)
					3'd1: op = OP_Q1;
					3'd2: op = OP_MID;
					default: op = OP_Q3;
				endcase
			end
		end else begin
			op = OP_CUR;
		end
	end

	for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_blend
		afrc_blend #(.W(SAMPLE_BITS)) u_blend (
			.held(held_s1[j]),
			.cur(cur_s1[j]),
			.op(op),
			.y(blend_y[j])
		);
	end

	// Held frame state is updated at acceptance; the stage keeps the old copy for blending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CHANNELS; j++) begin
				held_q[j] <= '0;
			end
			held_valid_q <= 1'b0;
			phase_q <= '0;
		end else if (accept) begin
			if (is_up) begin
				if (in_eob) begin
					for (int j = 0; j < MAX_CHANNELS; j++) begin
						held_q[j] <= '0;
					end
					held_valid_q <= 1'b0;
					phase_q <= '0;
				end else begin
					held_q <= x;
					held_valid_q <= 1'b1;
				end
			end else if (cfg.mode == MODE_DOWN) begin
				if (in_eob) begin
					for (int j = 0; j < MAX_CHANNELS; j++) begin
						held_q[j] <= '0;
					end
					held_valid_q <= 1'b0;
					phase_q <= '0;
				end else begin
					if (ds_emit) begin
						held_q <= x;
						held_valid_q <= 1'b1;
					end
					phase_q <= (phase_inc >= dec_m) ? 4'd0 : phase_inc[3:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (accept) begin
			busy_q <= count != 4'd0;
			idx_q <= '0;
		end else if (load_out) begin
			if (step_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= x;
			held_s1 <= held_q;
			mask_s1 <= act_mask;
			count_s1 <= count;
			pair_s1 <= held_valid_q;
			x4_s1 <= is_x4;
			down_s1 <= !is_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Channels at or above the active count, and any beyond MAX_CHANNELS, read as zero.
	always_comb begin
		for (int j = 0; j < CH_FIELDS; j++) begin
			out_next[j] = '0;
		end
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			out_next[j] = mask_s1[j] ? blend_y[j] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_s2 <= out_next;
			out_last_s2 <= step_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_smp = out_s2;
	assign out_last = out_last_s2;

endmodule

@@ src/audio_frame_rate_converter.sv @@
// Audio frame rate converter: takes one frame of up to eight signed samples per transfer and
// resamples by linear interpolation. Mode 0 upsamples by two, mode 1 by four (held frame,
// then 3:1, 1:1 and 1:3 blends toward the new frame), mode 2 keeps one frame in
// decimation_factor and averages it with the previous kept frame. The first frame of an
// upsampled block produces no result; the end-of-block frame is repeated two or four times.
// An item giving at most one result frees the input stage once its result, if any, enters the
// result register; otherwise one result is sent per cycle unless the result port stalls, and an
// item giving n results holds the port until all n are sent (four per frame in steady upsample
// by four, up to eight at end of block). The result register lets the next frame be taken while
// the last result still waits. Configuration must be written only while the block is idle;
// the block itself does not enforce it. Depends on afrc_pkg, afrc_if, afrc_cfg, afrc_core, afrc_blend.
module audio_frame_rate_converter
	import afrc_pkg::*;
#(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	afrc_frame_if.sink frames,
	afrc_result_if.source results,
	afrc_cfg_if.sink cfg
);

	cfg_t cfg_val;
	logic signed [SAMPLE_BITS-1:0] in_smp [CH_FIELDS];
	logic signed [SAMPLE_BITS-1:0] out_smp [CH_FIELDS];

	afrc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(cfg.valid),
		.wr_ready(cfg.ready),
		.wr_index(cfg.index),
		.wr_data(cfg.data),
		.cfg(cfg_val)
	);

	assign in_smp[0] = frames.sample_ch0;
	assign in_smp[1] = frames.sample_ch1;
	assign in_smp[2] = frames.sample_ch2;
	assign in_smp[3] = frames.sample_ch3;
	assign in_smp[4] = frames.sample_ch4;
	assign in_smp[5] = frames.sample_ch5;
	assign in_smp[6] = frames.sample_ch6;
	assign in_smp[7] = frames.sample_ch7;

	afrc_core #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_val),
		.in_valid(frames.valid),
		.in_ready(frames.ready),
		.in_smp(in_smp),
		.in_eob(frames.end_of_block),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_smp(out_smp),
		.out_last(results.last_of_run)
	);

	assign results.out_ch0 = out_smp[0];
	assign results.out_ch1 = out_smp[1];
	assign results.out_ch2 = out_smp[2];
	assign results.out_ch3 = out_smp[3];
	assign results.out_ch4 = out_smp[4];
	assign results.out_ch5 = out_smp[5];
	assign results.out_ch6 = out_smp[6];
	assign results.out_ch7 = out_smp[7];

endmodule
